### hw/rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master bit engine: request and result
// payloads, command codes and the engine state record.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_START     = 3'd1;
  localparam logic [2:0] MODE_STOP      = 3'd2;
  localparam logic [2:0] MODE_WRITE     = 3'd3;
  localparam logic [2:0] MODE_READ_ACK  = 3'd4;
  localparam logic [2:0] MODE_READ_NACK = 3'd5;

  localparam logic [1:0] PH_DRIVE = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  localparam logic [1:0] PH_LAST  = 2'd3;

  localparam logic [3:0] DATA_BITS = 4'd8;
  localparam int         MSB_POS   = 7;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] write_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
  } out_item_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] phase;
    logic [3:0] bit_idx;
    logic [7:0] shift;
    logic [7:0] tick;
    logic       scl;
    logic       sda;
    logic       ack;
    logic [7:0] last_read;
  } eng_state_t;

endpackage

### hw/rtl/i2cm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state and result logic for one tick of the bit engine.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  i2cm_pkg::eng_state_t st,
  input  i2cm_pkg::in_item_t   req,
  input  logic [7:0]           ticks_per_phase,
  output i2cm_pkg::eng_state_t st_nxt,
  output i2cm_pkg::out_item_t  res
);
  import i2cm_pkg::*;

  eng_state_t s;
  logic [7:0] lim;
  logic       last;
  logic       finish;
  logic       is_write;
  logic       data_slot;

  always_comb begin
    s      = st;
    finish = 1'b0;

    if (s.cmd == MODE_NONE && req.mode >= MODE_START && req.mode <= MODE_READ_NACK) begin
      s.cmd     = req.mode;
      s.phase   = PH_DRIVE;
      s.bit_idx = 4'd0;
      s.tick    = 8'd0;
      s.shift   = (req.mode == MODE_WRITE) ? req.write_byte : 8'd0;
    end

    lim       = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
    last      = ({1'b0, s.tick} + 9'd1) >= {1'b0, lim};
    is_write  = (s.cmd == MODE_WRITE);
    data_slot = (s.bit_idx < DATA_BITS);

    if (s.cmd == MODE_START) begin
      case (s.phase)
        PH_DRIVE: s.sda = 1'b1;
        PH_HIGH:  s.scl = 1'b1;
        PH_LOW:   s.sda = 1'b0;
        default:  s.scl = 1'b0;
      endcase
      if (last) begin
        if (s.phase == PH_LAST) finish = 1'b1;
        else s.phase = s.phase + 2'd1;
      end
    end else if (s.cmd == MODE_STOP) begin
      case (s.phase)
        PH_DRIVE: s.sda = 1'b0;
        PH_HIGH:  s.scl = 1'b1;
        default:  s.sda = 1'b1;
      endcase
      if (last) begin
        if (s.phase >= PH_LOW) finish = 1'b1;
        else s.phase = s.phase + 2'd1;
      end
    end else if (s.cmd != MODE_NONE) begin
      case (s.phase)
        PH_DRIVE: begin
          if (data_slot) s.sda = is_write ? s.shift[MSB_POS] : 1'b1;
          else s.sda = (s.cmd == MODE_READ_ACK) ? 1'b0 : 1'b1;
          if (last) s.phase = PH_HIGH;
        end
        PH_HIGH: begin
          s.scl = 1'b1;
          if (last) begin
            if (data_slot) begin
              if (!is_write) s.shift = {s.shift[6:0], req.sda_in};
            end else if (is_write) begin
              s.ack = req.sda_in;
            end
            s.phase = PH_LOW;
          end
        end
        default: begin
          s.scl = 1'b0;
          if (last) begin
            if (is_write && data_slot) s.shift = {s.shift[6:0], 1'b0};
            if (!data_slot) begin
              finish = 1'b1;
              if (!is_write) s.last_read = s.shift;
            end else begin
              s.bit_idx = s.bit_idx + 4'd1;
              s.phase   = PH_DRIVE;
            end
          end
        end
      endcase
    end

    if (s.cmd != MODE_NONE) begin
      s.tick = last ? 8'd0 : s.tick + 8'd1;
    end

    if (finish) begin
      s.cmd     = MODE_NONE;
      s.phase   = PH_DRIVE;
      s.bit_idx = 4'd0;
      s.tick    = 8'd0;
    end

    st_nxt        = s;
    res.scl_out   = s.scl;
    res.sda_out   = s.sda;
    res.busy_res  = (s.cmd != MODE_NONE);
    res.done_res  = finish;
    res.read_byte = s.last_read;
    res.ack_seen  = s.ack;
  end

endmodule

### hw/rtl/i2cm_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_out_reg
// Result register with valid/ready handshake towards the consumer.
// ----------------------------------------------------------------------------
module i2cm_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  i2cm_pkg::out_item_t load_item,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_item
);
  import i2cm_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

### hw/rtl/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Bit-level I2C master: start, stop, byte write with acknowledge sampling,
// byte read with acknowledge or not-acknowledge, one bus tick per request.
// ----------------------------------------------------------------------------
// Every request is one bus tick and yields exactly one result. The engine
// takes one request per clock unless the result register is stalled by
// out_ready: the request is held in an input register, one tick of the
// phase sequencer runs between that register and the result register, and
// in_ready follows out_ready through those two stages. Each bus phase lasts
// ticks_per_phase requests (zero counts as one). Write the configuration
// only while no command is in progress and no result is outstanding.
module i2c_master_bit_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import i2cm_pkg::*;

  logic       req_valid_r;
  logic       req_valid_nxt;
  in_item_t   req_r;
  logic [7:0] tpp_r;
  eng_state_t st_r;
  eng_state_t st_nxt;
  out_item_t  res;
  logic       can_load;
  logic       adv;

  assign cfg_ready     = 1'b1;
  assign adv           = req_valid_r && can_load;
  assign in_ready      = !req_valid_r || adv;
  assign req_valid_nxt = (in_valid && in_ready) || (req_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      tpp_r       <= 8'd1;
      st_r        <= '{cmd: MODE_NONE, phase: PH_DRIVE, bit_idx: 4'd0, shift: 8'd0,
                       tick: 8'd0, scl: 1'b1, sda: 1'b1, ack: 1'b1, last_read: 8'd0};
    end else begin
      req_valid_r <= req_valid_nxt;
      if (cfg_valid) tpp_r <= cfg_data;
      if (adv) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_item;
    end
  end

  i2cm_step u_step (
    .st              (st_r),
    .req             (req_r),
    .ticks_per_phase (tpp_r),
    .st_nxt          (st_nxt),
    .res             (res)
  );

  i2cm_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .load_item (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cmd == MODE_NONE |-> (st_r.phase == PH_DRIVE && st_r.bit_idx == 4'd0
                               && st_r.tick == 8'd0))
    else $error("idle engine left with stale sequence counters");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bit_idx <= DATA_BITS)
    else $error("bit slot index beyond acknowledge slot");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.done_res) |=> st_r.cmd == MODE_NONE)
    else $error("command finished but engine still active");

  a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && !adv) |=> (req_valid_r && $stable(req_r)))
    else $error("stalled request lost or overwritten");

endmodule
